FILE: design/nirc_pkg.sv
// nirc_pkg: shared types, constants and window check of the nec ir command decoder
// no dependencies
`timescale 1ns / 1ps

package nirc_pkg;

    localparam int MAX_PAIRS_DEF = 48;
    localparam int TICK_W        = 16;
    localparam int CODE_W        = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int NUM_BITS      = 32;
    localparam int REPEAT_COUNT  = 2;
    localparam int FRAME_COUNT   = 35;

    localparam logic [CODE_W-1:0] KEY_FORWARD_RST  = 32'h00ff_a05f;
    localparam logic [CODE_W-1:0] KEY_BACKWARD_RST = 32'h00ff_40bf;
    localparam logic [CODE_W-1:0] KEY_LEFT_RST     = 32'h00ff_50af;
    localparam logic [CODE_W-1:0] KEY_RIGHT_RST    = 32'h00ff_7887;
    localparam logic [CODE_W-1:0] KEY_STOP_RST     = 32'h00ff_02fd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_FORWARD  = 3'd0,
        CFG_KEY_BACKWARD = 3'd1,
        CFG_KEY_LEFT     = 3'd2,
        CFG_KEY_RIGHT    = 3'd3,
        CFG_KEY_STOP     = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_PREAMBLE_ERR = 3'd0,
        ST_REPEAT       = 3'd1,
        ST_DECODED      = 3'd2,
        ST_BIT_ERR      = 3'd3,
        ST_WRONG_COUNT  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        HIT_NONE     = 3'd0,
        HIT_FORWARD  = 3'd1,
        HIT_BACKWARD = 3'd2,
        HIT_LEFT     = 3'd3,
        HIT_RIGHT    = 3'd4,
        HIT_STOP     = 3'd5
    } hit_t;

    typedef enum logic [1:0] {
        DIR_FWD  = 2'd0,
        DIR_BWD  = 2'd1,
        DIR_STOP = 2'd2
    } dir_t;

    typedef struct packed {
        logic              done;
        status_t           status;
        logic [CODE_W-1:0] code;
    } frame_end_t;

    typedef struct packed {
        status_t           status;
        logic [CODE_W-1:0] code;
        hit_t              hit;
        dir_t              left;
        dir_t              right;
    } result_t;

    // v within [floor(c*19/20), floor(c*21/20)] without a divider
    function automatic logic in_window(input logic [TICK_W-1:0] v,
                                       input logic [TICK_W-1:0] c);
        logic [21:0] v20;
        logic [21:0] c19;
        logic [21:0] c21;
        v20 = 22'(v) * 22'd20;
        c19 = 22'(c) * 22'd19;
        c21 = 22'(c) * 22'd21;
        return ((v20 + 22'd20) > c19) && (v20 <= c21);
    endfunction

endpackage

FILE: design/nirc_if.sv
// nirc_pair_if and nirc_result_if: valid/ready channels of the decoder
// depends on nirc_pkg
`timescale 1ns / 1ps

interface nirc_pair_if;
    logic                        valid;
    logic                        ready;
    logic [nirc_pkg::TICK_W-1:0] mark_count;
    logic [nirc_pkg::TICK_W-1:0] space_count;
    logic                        last_pair;

    modport source (output valid, output mark_count, output space_count,
                    output last_pair, input ready);
    modport sink (input valid, input mark_count, input space_count,
                  input last_pair, output ready);
endinterface

interface nirc_result_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  frame_status;
    logic [nirc_pkg::CODE_W-1:0] code_word;
    logic [2:0]                  key_hit;
    logic [1:0]                  left_state;
    logic [1:0]                  right_state;

    modport source (output valid, output frame_status, output code_word,
                    output key_hit, output left_state, output right_state,
                    input ready);
    modport sink (input valid, input frame_status, input code_word,
                  input key_hit, input left_state, input right_state,
                  output ready);
endinterface

FILE: design/nirc_frame_decoder.sv
// nirc_frame_decoder: per-pair timing checks, code shifting and frame end detection
// depends on nirc_pkg
`timescale 1ns / 1ps

module nirc_frame_decoder #(
    parameter int MAX_PAIRS = nirc_pkg::MAX_PAIRS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  logic [nirc_pkg::TICK_W-1:0] mark_count,
    input  logic [nirc_pkg::TICK_W-1:0] space_count,
    input  logic                        last_pair,
    output nirc_pkg::frame_end_t        frame_end
);
    import nirc_pkg::*;

    localparam int IDX_W = $clog2(MAX_PAIRS);
    localparam int CNT_W = $clog2(MAX_PAIRS + 1);

    logic [IDX_W-1:0]  idx_reg;
    logic [TICK_W-1:0] unit_reg;
    logic [CODE_W-1:0] code_reg;
    logic              failed_reg;
    logic              pre_bad_reg;

    logic [TICK_W-1:0] unit_next;
    logic [CODE_W-1:0] code_next;
    logic              failed_next;
    logic              pre_bad_next;
    logic [TICK_W-1:0] pair_sum;
    logic [CNT_W-1:0]  count;
    logic              done;
    status_t           status;

    always_comb
    begin
        pair_sum     = mark_count + space_count;
        unit_next    = unit_reg;
        pre_bad_next = pre_bad_reg;
        code_next    = code_reg;
        failed_next  = failed_reg;
        if (idx_reg == '0)
        begin
            unit_next = mark_count;
            if (!in_window(space_count, {1'b0, mark_count[TICK_W-1:1]}))
            begin
                pre_bad_next = 1'b1;
            end
        end
        else if ((idx_reg <= IDX_W'(NUM_BITS)) && !failed_reg)
        begin
            code_next = {code_reg[CODE_W-2:0], 1'b0};
            if (in_window(pair_sum, {3'b0, unit_reg[TICK_W-1:3]}))
            begin
                code_next[0] = 1'b0;
            end
            else if (in_window(pair_sum, {2'b0, unit_reg[TICK_W-1:2]}))
            begin
                code_next[0] = 1'b1;
            end
            else
            begin
                failed_next = 1'b1;
            end
        end

        count = CNT_W'(idx_reg) + CNT_W'(1);
        done  = last_pair || (count >= CNT_W'(MAX_PAIRS));

        if (pre_bad_next)
        begin
            status = ST_PREAMBLE_ERR;
        end
        else if (count == CNT_W'(REPEAT_COUNT))
        begin
            status = ST_REPEAT;
        end
        else if (count == CNT_W'(FRAME_COUNT))
        begin
            status = failed_next ? ST_BIT_ERR : ST_DECODED;
        end
        else
        begin
            status = ST_WRONG_COUNT;
        end

        frame_end.done   = done;
        frame_end.status = status;
        frame_end.code   = (status == ST_DECODED || status == ST_BIT_ERR) ?
                           code_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            unit_reg    <= '0;
            code_reg    <= '0;
            failed_reg  <= 1'b0;
            pre_bad_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (done)
            begin
                idx_reg     <= '0;
                unit_reg    <= '0;
                code_reg    <= '0;
                failed_reg  <= 1'b0;
                pre_bad_reg <= 1'b0;
            end
            else
            begin
                idx_reg     <= IDX_W'(count);
                unit_reg    <= unit_next;
                code_reg    <= code_next;
                failed_reg  <= failed_next;
                pre_bad_reg <= pre_bad_next;
            end
        end
    end

endmodule

FILE: design/nirc_motor_ctrl.sv
// nirc_motor_ctrl: key registers, key match and left/right direction state
// depends on nirc_pkg
`timescale 1ns / 1ps

module nirc_motor_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [nirc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [nirc_pkg::CFG_DATA_W-1:0] wr_data,
    input  logic                            fire,
    input  nirc_pkg::frame_end_t            frame_end,
    output nirc_pkg::result_t               result
);
    import nirc_pkg::*;

    logic [CODE_W-1:0] key_fwd_reg;
    logic [CODE_W-1:0] key_bwd_reg;
    logic [CODE_W-1:0] key_left_reg;
    logic [CODE_W-1:0] key_right_reg;
    logic [CODE_W-1:0] key_stop_reg;
    dir_t              left_reg;
    dir_t              right_reg;
    dir_t              left_next;
    dir_t              right_next;
    hit_t              hit;
    logic              decoded;

    always_comb
    begin
        decoded    = (frame_end.status == ST_DECODED) ||
                     (frame_end.status == ST_BIT_ERR);
        left_next  = left_reg;
        right_next = right_reg;
        hit        = HIT_NONE;
        if (decoded)
        begin
            if (frame_end.code == key_fwd_reg)
            begin
                hit = HIT_FORWARD;
                if (left_reg == DIR_BWD && right_reg == DIR_BWD)
                begin
                    left_next  = DIR_STOP;
                    right_next = DIR_STOP;
                end
                else
                begin
                    left_next  = DIR_FWD;
                    right_next = DIR_FWD;
                end
            end
            else if (frame_end.code == key_bwd_reg)
            begin
                hit = HIT_BACKWARD;
                if (left_reg == DIR_FWD && right_reg == DIR_FWD)
                begin
                    left_next  = DIR_STOP;
                    right_next = DIR_STOP;
                end
                else
                begin
                    left_next  = DIR_BWD;
                    right_next = DIR_BWD;
                end
            end
            else if (frame_end.code == key_left_reg)
            begin
                hit        = HIT_LEFT;
                left_next  = DIR_BWD;
                right_next = DIR_FWD;
            end
            else if (frame_end.code == key_right_reg)
            begin
                hit        = HIT_RIGHT;
                left_next  = DIR_FWD;
                right_next = DIR_BWD;
            end
            else if (frame_end.code == key_stop_reg)
            begin
                hit        = HIT_STOP;
                left_next  = DIR_STOP;
                right_next = DIR_STOP;
            end
        end

        result.status = frame_end.status;
        result.code   = frame_end.code;
        result.hit    = hit;
        result.left   = left_next;
        result.right  = right_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_fwd_reg   <= KEY_FORWARD_RST;
            key_bwd_reg   <= KEY_BACKWARD_RST;
            key_left_reg  <= KEY_LEFT_RST;
            key_right_reg <= KEY_RIGHT_RST;
            key_stop_reg  <= KEY_STOP_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_KEY_FORWARD:  key_fwd_reg   <= wr_data;
                CFG_KEY_BACKWARD: key_bwd_reg   <= wr_data;
                CFG_KEY_LEFT:     key_left_reg  <= wr_data;
                CFG_KEY_RIGHT:    key_right_reg <= wr_data;
                CFG_KEY_STOP:     key_stop_reg  <= wr_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= DIR_STOP;
            right_reg <= DIR_STOP;
        end
        else if (fire && frame_end.done)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

endmodule

FILE: design/nec_ir_remote_command_decoder.sv
// nec_ir_remote_command_decoder: top level with input and result registers
// depends on nirc_pkg, nirc_if, nirc_frame_decoder, nirc_motor_ctrl
`timescale 1ns / 1ps

// Takes one measured mark/space pair per beat and gives one result beat when a
// frame ends (last_pair set, or MAX_PAIRS pairs seen). A pair is registered on
// entry and then processed by one pass of window compares, code shift and key
// match; a pair is taken every cycle unless the input stalls, and the result of
// a frame-ending pair goes into the result register. That register lets the next
// pair in while a result waits; the input stalls only when a frame-ending pair
// finds it still full. Key registers are written through wr_en/wr_index/wr_data;
// the user must do so only while no frame is in flight, the block does not check.
module nec_ir_remote_command_decoder #(
    parameter int MAX_PAIRS = nirc_pkg::MAX_PAIRS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    nirc_pair_if.sink                       pair_in,
    nirc_result_if.source                   result_out,
    input  logic                            wr_en,
    input  logic [nirc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [nirc_pkg::CFG_DATA_W-1:0] wr_data
);
    import nirc_pkg::*;

    logic              in_valid_reg;
    logic [TICK_W-1:0] mark_reg;
    logic [TICK_W-1:0] space_reg;
    logic              last_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_reg;

    frame_end_t        frame_end;
    result_t           result;
    logic              fire;
    logic              load;

    nirc_frame_decoder #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .mark_count  (mark_reg),
        .space_count (space_reg),
        .last_pair   (last_reg),
        .frame_end   (frame_end)
    );

    nirc_motor_ctrl u_motor (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .fire      (fire),
        .frame_end (frame_end),
        .result    (result)
    );

    always_comb
    begin
        fire = in_valid_reg &&
               (!frame_end.done || !out_valid_reg || result_out.ready);
        load = fire && frame_end.done;
        pair_in.ready = !in_valid_reg || fire;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pair_in.ready)
            begin
                in_valid_reg <= pair_in.valid;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pair_in.ready && pair_in.valid)
        begin
            mark_reg  <= pair_in.mark_count;
            space_reg <= pair_in.space_count;
            last_reg  <= pair_in.last_pair;
        end
        if (load)
        begin
            out_reg <= result;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.frame_status = out_reg.status;
    assign result_out.code_word    = out_reg.code;
    assign result_out.key_hit      = out_reg.hit;
    assign result_out.left_state   = out_reg.left;
    assign result_out.right_state  = out_reg.right;

endmodule
